>>> design/channel_occupancy_tracker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the channel occupancy tracker
// Shared concurrent-assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CHANNEL_OCCUPANCY_TRACKER_MACROS_SVH
`define CHANNEL_OCCUPANCY_TRACKER_MACROS_SVH

// Check a property at every edge.
`define COT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define COT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define COT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cot_pkg.sv
// ---------------------------------------------------------------------------
// Channel occupancy tracker package
// Operation codes and the queue entry passed from the front to the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cot_pkg;

  localparam int MAX_ADDR_W  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_MEAS = 2'd1;
  localparam logic [1:0] OP_FAIL = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [MAX_ADDR_W-1:0] addr;
    logic [6:0]            chan;
    logic                  hit;
    logic                  in_range;
    logic                  done;
    logic [31:0]           sweep_total;
    logic [31:0]           hit_total;
  } cot_entry_t;

endpackage

>>> design/channel_occupancy_tracker.sv
// ---------------------------------------------------------------------------
// Channel occupancy tracker
// Per-channel exponential-average occupancy table driven by detector words.
// ---------------------------------------------------------------------------
// Path: an accepted word goes into the queue, then into the table read and
//   update stage, then into the output register behind out_valid.
// Throughput: one word per cycle while out_stall is low, set by the single
//   read and write port of the table; a write to the channel just read is
//   forwarded. Reset: pointer, totals, queue and pipe clear; per-entry valid
//   bits make the whole table read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module channel_occupancy_tracker import cot_pkg::*; #(
  parameter int CHANNEL_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  detector_byte,
  input  logic        transport_ok,
  input  logic [6:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  channel_index,
  output logic [7:0]  occupancy,
  output logic        failed,
  output logic        sweep_done,
  output logic [31:0] sweep_total,
  output logic [31:0] hit_total
);

  // Front to queue: one classified entry per accepted word.
  logic       push;
  cot_entry_t push_entry;
  logic       q_full;

  // Queue to back.
  cot_entry_t head;
  logic       q_empty;
  logic       pop;

  // Classify the word, advance the scan pointer and the totals.
  cot_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .detector_byte(detector_byte),
    .transport_ok (transport_ok),
    .read_index   (read_index),
    .q_full       (q_full),
    .push         (push),
    .entry        (push_entry)
  );

  // Decouple the front from table access and output backpressure.
  cot_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Read, update and write the table; hold the result for the consumer.
  cot_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_index(channel_index),
    .occupancy    (occupancy),
    .failed       (failed),
    .sweep_done   (sweep_done),
    .sweep_total  (sweep_total),
    .hit_total    (hit_total)
  );

endmodule

>>> design/cot_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/cot_front.sv
// ---------------------------------------------------------------------------
// Channel occupancy tracker front
// Accepts words, classifies them, keeps pointer and totals, fills the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cot_front import cot_pkg::*; #(
  parameter int CHANNEL_COUNT = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] detector_byte,
  input  logic       transport_ok,
  input  logic [6:0] read_index,
  input  logic       q_full,
  output logic       push,
  output cot_entry_t entry
);

  localparam int AW = $clog2(CHANNEL_COUNT);

  logic [AW-1:0] pointer;
  logic [AW-1:0] pointer_next;
  logic [31:0]   sweep_count;
  logic [31:0]   sweep_count_next;
  logic [31:0]   hit_count;
  logic [31:0]   hit_count_next;

  logic       meas_ok;
  logic       hit;
  logic       last;
  logic [8:0] ptr_ext;
  logic [8:0] ridx_ext;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign ptr_ext  = 9'(pointer);
  assign ridx_ext = 9'(read_index);
  assign meas_ok  = transport_ok && (detector_byte <= 8'd1);
  assign hit      = meas_ok && (detector_byte != 8'd0);
  assign last     = (pointer == AW'(CHANNEL_COUNT - 1));

  always_comb begin
    pointer_next     = pointer;
    sweep_count_next = sweep_count;
    hit_count_next   = hit_count;
    entry            = '0;
    if (kind == KIND_READ) begin
      entry.op       = OP_READ;
      entry.addr     = ridx_ext[MAX_ADDR_W-1:0];
      entry.chan     = read_index;
      entry.in_range = (ridx_ext < 9'(CHANNEL_COUNT));
    end else begin
      entry.op       = meas_ok ? OP_MEAS : OP_FAIL;
      entry.addr     = ptr_ext[MAX_ADDR_W-1:0];
      entry.chan     = ptr_ext[6:0];
      entry.in_range = 1'b1;
      entry.hit      = hit;
      entry.done     = meas_ok && last;
      if (meas_ok) begin
        pointer_next = last ? '0 : pointer + AW'(1);
        if (last) begin
          sweep_count_next = sweep_count + 32'd1;
        end
        if (hit) begin
          hit_count_next = hit_count + 32'd1;
        end
      end
    end
    entry.sweep_total = sweep_count_next;
    entry.hit_total   = hit_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer     <= '0;
      sweep_count <= '0;
      hit_count   <= '0;
    end else if (push) begin
      pointer     <= pointer_next;
      sweep_count <= sweep_count_next;
      hit_count   <= hit_count_next;
    end
  end

endmodule

>>> design/cot_fifo.sv
// ---------------------------------------------------------------------------
// Channel occupancy tracker queue
// Short queue of classified entries between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "channel_occupancy_tracker_macros.svh"

module cot_fifo import cot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cot_entry_t push_entry,
  input  logic       pop,
  output cot_entry_t head,
  output logic       empty,
  output logic       full
);

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cot_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `COT_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count above depth")
  `COT_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `COT_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !empty, "pop from empty queue")

endmodule

>>> design/cot_back.sv
// ---------------------------------------------------------------------------
// Channel occupancy tracker back
// Reads the table, applies the average update, writes back, holds the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "channel_occupancy_tracker_macros.svh"

module cot_back import cot_pkg::*; #(
  parameter int CHANNEL_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  cot_entry_t  head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  channel_index,
  output logic [7:0]  occupancy,
  output logic        failed,
  output logic        sweep_done,
  output logic [31:0] sweep_total,
  output logic [31:0] hit_total
);

  localparam int AW = $clog2(CHANNEL_COUNT);

  logic               advance;
  logic               we;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [7:0]         rdata;
  logic [7:0]         old_occ;
  logic [7:0]         new_occ;
  logic [7:0]         res_occ;
  logic [8:0]         up_step;
  logic [10:0]        times7;

  logic [CHANNEL_COUNT-1:0] vld;

  logic       r_valid;
  cot_entry_t r_entry;
  logic       r_fwd;
  logic [7:0] r_fwd_data;
  logic       r_vld;

  // Move the pipe whenever the output register is free or being taken.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;
  assign raddr   = head.addr[AW-1:0];
  assign waddr   = r_entry.addr[AW-1:0];
  assign we      = advance && r_valid && (r_entry.op == OP_MEAS);

  assign old_occ = r_fwd ? r_fwd_data : (r_vld ? rdata : 8'd0);
  assign up_step = ({1'b0, ~old_occ} + 9'd7) >> 3;
  assign times7  = {old_occ, 3'b000} - {3'b000, old_occ};
  assign new_occ = r_entry.hit ? (old_occ + up_step[7:0]) : times7[10:3];

  always_comb begin
    case (r_entry.op)
      OP_MEAS: res_occ = new_occ;
      OP_READ: res_occ = r_entry.in_range ? old_occ : 8'd0;
      OP_FAIL: res_occ = old_occ;
      default: res_occ = old_occ;
    endcase
  end

  cot_ram #(
    .WIDTH(8),
    .DEPTH(CHANNEL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(new_occ),
    .re   (pop),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (advance) begin
        r_valid   <= pop;
        out_valid <= r_valid;
      end
    end
  end

  // Payload: capture the entry with its read, forward a same-edge write.
  always_ff @(posedge clk) begin
    if (pop) begin
      r_entry    <= head;
      r_fwd      <= we && (waddr == raddr);
      r_fwd_data <= new_occ;
      r_vld      <= vld[raddr];
    end
    if (advance && r_valid) begin
      channel_index <= r_entry.chan;
      occupancy     <= res_occ;
      failed        <= (r_entry.op == OP_FAIL);
      sweep_done    <= r_entry.done;
      sweep_total   <= r_entry.sweep_total;
      hit_total     <= r_entry.hit_total;
    end
  end

  `COT_ASSERT_IMPL(a_no_write_stalled, clk, rst, out_valid && out_stall, !we,
                   "table written while result stalled")
  `COT_ASSERT_NEXT(a_pop_fills_stage, clk, rst, pop, r_valid,
                   "read stage empty after pop")
  `COT_ASSERT_NEXT(a_stage_drains, clk, rst, advance && r_valid, out_valid,
                   "result lost on advance")

endmodule

>>> sim/tb_channel_occupancy_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Channel occupancy tracker testbench
// Sends detector and read words through the valid/stall input channel,
// predicts every result with an in-bench occupancy table and compares each
// result word field by field. The sender runs steady or in bursts with
// gaps and the receiver stalls on a changing pattern of its own.
// ---------------------------------------------------------------------------

module tb_channel_occupancy_tracker;
  import cot_pkg::*;

  localparam int CHANNELS     = 128;
  localparam int RANDOM_WORDS = 800;
  localparam int DRAIN_LIMIT  = 5000;

  typedef enum logic { TX_STEADY, TX_BURSTY } tx_mode_t;
  typedef enum logic [1:0] { RX_FREE, RX_SPARSE, RX_LONG } rx_mode_t;

  // One result word as the block should present it.
  typedef struct packed {
    logic [6:0]  chan;
    logic [7:0]  occ;
    logic        failed;
    logic        done;
    logic [31:0] sweeps;
    logic [31:0] hits;
  } occ_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        kind          = KIND_MEASURE;
  logic [7:0]  detector_byte = 8'd0;
  logic        transport_ok  = 1'b0;
  logic [6:0]  read_index    = 7'd0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [6:0]  channel_index;
  logic [7:0]  occupancy;
  logic        failed;
  logic        sweep_done;
  logic [31:0] sweep_total;
  logic [31:0] hit_total;

  channel_occupancy_tracker #(
    .CHANNEL_COUNT(CHANNELS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .detector_byte(detector_byte),
    .transport_ok (transport_ok),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_index(channel_index),
    .occupancy    (occupancy),
    .failed       (failed),
    .sweep_done   (sweep_done),
    .sweep_total  (sweep_total),
    .hit_total    (hit_total)
  );

  // Predicted tracker state, updated on every accepted input word.
  logic [7:0]  occ_table [CHANNELS];
  logic [6:0]  scan_ptr = 7'd0;
  logic [31:0] sweep_cnt = 32'd0;
  logic [31:0] hit_cnt = 32'd0;

  occ_result_t expected_q[$];
  int          error_count = 0;

  // Sender pacing state.
  tx_mode_t    tx_mode = TX_BURSTY;
  int          burst_left = 0;

  // Generator-side copy of the scan pointer, used to aim reads at channels
  // that were just written.
  logic [6:0]  gen_ptr = 7'd0;

  // Receiver stall pattern state.
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_left = 0;
  int          rx_hold = 0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) occ_table[i] = 8'd0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor: apply one input word to the tracker state and return the
  // result word it produces.
  // -------------------------------------------------------------------------
  function automatic occ_result_t advance_tracker(logic k, logic [7:0] det, logic tok,
                                                  logic [6:0] ridx);
    occ_result_t r;
    int          old_occ;
    r.failed = 1'b0;
    r.done   = 1'b0;
    if (k == KIND_READ) begin
      // Echo the index; out-of-range channels read as empty.
      r.chan = ridx;
      r.occ  = (int'(ridx) < CHANNELS) ? occ_table[ridx] : 8'd0;
    end else begin
      r.chan = scan_ptr;
      if (tok && det <= 8'd1) begin
        old_occ = occ_table[scan_ptr];
        if (det != 8'd0) begin
          // Rise by a rounded-up eighth of the headroom.
          occ_table[scan_ptr] = 8'(old_occ + (255 - old_occ + 7) / 8);
          hit_cnt = hit_cnt + 32'd1;
        end else begin
          // Decay to seven eighths, rounded down.
          occ_table[scan_ptr] = 8'((old_occ * 7) / 8);
        end
        if (int'(scan_ptr) == CHANNELS - 1) begin
          sweep_cnt = sweep_cnt + 32'd1;
          r.done    = 1'b1;
        end
        r.occ    = occ_table[scan_ptr];
        scan_ptr = 7'((int'(scan_ptr) + 1) % CHANNELS);
      end else begin
        // Invalid reading: report the current channel untouched.
        r.failed = 1'b1;
        r.occ    = occ_table[scan_ptr];
      end
    end
    r.sweeps = sweep_cnt;
    r.hits   = hit_cnt;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: predict on each accepted input word, then check each accepted
  // result word against the oldest prediction. Both run in one process so
  // their order is fixed.
  // -------------------------------------------------------------------------
  occ_result_t want;
  occ_result_t got;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_q.push_back(advance_tracker(kind, detector_byte, transport_ok, read_index));

      if (out_valid && !out_stall) begin
        got = '{channel_index, occupancy, failed, sweep_done, sweep_total, hit_total};
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: chan %0d occ %0d", $time,
                   channel_index, occupancy);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.chan !== want.chan) begin
            $display("%0t: channel_index expected %0d actual %0d", $time, want.chan, got.chan);
            error_count++;
          end
          if (got.occ !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
            error_count++;
          end
          if (got.failed !== want.failed) begin
            $display("%0t: failed expected %0b actual %0b", $time, want.failed, got.failed);
            error_count++;
          end
          if (got.done !== want.done) begin
            $display("%0t: sweep_done expected %0b actual %0b", $time, want.done, got.done);
            error_count++;
          end
          if (got.sweeps !== want.sweeps) begin
            $display("%0t: sweep_total expected %0d actual %0d", $time, want.sweeps,
                     got.sweeps);
            error_count++;
          end
          if (got.hits !== want.hits) begin
            $display("%0t: hit_total expected %0d actual %0d", $time, want.hits, got.hits);
            error_count++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: pick at random among no stall, sparse random stalls and stall
  // runs, drawing a new mode each time the mode countdown runs out.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(64, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_SPARSE: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (rx_hold != 0) begin
          out_stall <= 1'b1;
          rx_hold   <= rx_hold - 1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 8);
        end
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sender helpers
  // -------------------------------------------------------------------------

  // Insert a random gap between bursts; hold valid high inside a burst.
  task automatic pace_sender();
    int gap;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // Present one word and hold it until accepted.
  task automatic send_word(logic k, logic [7:0] det, logic tok, logic [6:0] ridx);
    kind          <= k;
    detector_byte <= det;
    transport_ok  <= tok;
    read_index    <= ridx;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_MEASURE && tok && det <= 8'd1) gen_ptr = 7'((int'(gen_ptr) + 1) % CHANNELS);
    pace_sender();
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_q.size());
      error_count++;
      expected_q.delete();
    end
  endtask

  // Random valid reading with the given hit chance in percent.
  task automatic send_reading(int hit_pct);
    send_word(KIND_MEASURE, ($urandom_range(0, 99) < hit_pct) ? 8'd1 : 8'd0, 1'b1,
              7'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Channels 0, 64 and 127 read as zero after reset; an invalid reading at
  // channel zero leaves it alone.
  task automatic test_reset_state();
    tx_mode = TX_BURSTY;
    send_word(KIND_READ, 8'd0, 1'b0, 7'd0);
    send_word(KIND_READ, 8'hFF, 1'b1, 7'd127);
    send_word(KIND_READ, 8'h55, 1'b0, 7'd64);
    send_word(KIND_MEASURE, 8'd2, 1'b1, 7'd0);
  endtask

  // Field extremes, every kind of invalid reading, ignored fields and a read
  // right behind a write to the same channel.
  task automatic test_directed_words();
    send_word(KIND_MEASURE, 8'd1, 1'b1, 7'd0);     // hit on channel 0
    send_word(KIND_MEASURE, 8'd0, 1'b1, 7'd127);   // miss on empty channel, index ignored
    send_word(KIND_MEASURE, 8'd2, 1'b1, 7'd5);     // byte just above valid range
    send_word(KIND_MEASURE, 8'd255, 1'b1, 7'd0);   // largest byte
    send_word(KIND_MEASURE, 8'd1, 1'b0, 7'd0);     // hit with transport failure
    send_word(KIND_MEASURE, 8'd0, 1'b0, 7'd127);   // miss with transport failure
    send_word(KIND_MEASURE, 8'hAA, 1'b0, 7'd85);   // both wrong
    send_word(KIND_READ, 8'hFF, 1'b0, 7'd0);       // read ignores detector fields
    send_word(KIND_MEASURE, 8'd1, 1'b1, 7'd42);    // hit channel 2
    send_word(KIND_READ, 8'd1, 1'b1, 7'd2);        // read right behind the write
    send_word(KIND_MEASURE, 8'd1, 1'b1, 7'd0);     // hit channel 3
    send_word(KIND_MEASURE, 8'd0, 1'b1, 7'd0);     // miss channel 4
    send_word(KIND_READ, 8'd0, 1'b1, 7'd3);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd127);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd1);
  endtask

  // Hold off the sender until the block has returned everything.
  task automatic test_idle_pause();
    drain_results();
    repeat ($urandom_range(3, 10)) @(posedge clk);
    send_word(KIND_READ, 8'd0, 1'b0, 7'd0);
    send_word(KIND_MEASURE, 8'd1, 1'b1, 7'd0);
  endtask

  // Random segments: mostly valid readings at a varying hit rate, with reads
  // (often at the channel just written) and invalid readings mixed in.
  task automatic test_random_traffic();
    int sent;
    int seg_len;
    int hit_pct;
    int pick;
    logic [6:0] ridx;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      seg_len = $urandom_range(50, 200);
      case ($urandom_range(0, 4))
        0: hit_pct = 0;
        1: hit_pct = 10;
        2: hit_pct = 50;
        3: hit_pct = 90;
        default: hit_pct = 100;
      endcase
      tx_mode = ($urandom_range(0, 3) == 0) ? TX_STEADY : TX_BURSTY;
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_reading(hit_pct);
        end else if (pick < 82) begin
          case ($urandom_range(0, 3))
            0: ridx = 7'(int'(gen_ptr) - 1);
            1: ridx = gen_ptr;
            default: ridx = 7'($urandom);
          endcase
          send_word(KIND_READ, 8'($urandom), 1'($urandom), ridx);
        end else if (pick < 91) begin
          send_word(KIND_MEASURE, 8'($urandom), 1'b0, 7'($urandom));
        end else begin
          send_word(KIND_MEASURE, 8'($urandom_range(2, 255)), 1'($urandom), 7'($urandom));
        end
        sent++;
      end
    end
  endtask

  // Sweep every channel with hits and then with misses, steady and in
  // bursts, so each channel climbs and then decays over several sweeps.
  task automatic test_saturate_decay();
    tx_mode = TX_STEADY;
    repeat (3 * CHANNELS) send_reading(100);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd0);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd127);
    tx_mode = TX_BURSTY;
    repeat (CHANNELS) send_reading(100);
    tx_mode = TX_STEADY;
    repeat (3 * CHANNELS) send_reading(0);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd0);
    send_word(KIND_READ, 8'd0, 1'b1, 7'd127);
    tx_mode = TX_BURSTY;
    repeat (CHANNELS + 3) send_reading(0);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_words();
    test_idle_pause();
    test_random_traffic();
    test_saturate_decay();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> channel_occupancy_tracker.f
+incdir+design
design/cot_pkg.sv
design/cot_ram.sv
design/cot_front.sv
design/cot_fifo.sv
design/cot_back.sv
design/channel_occupancy_tracker.sv
sim/tb_channel_occupancy_tracker.sv
